>>> hw/rtl/sipct_pkg.sv
package sipct_pkg;

    // Event kinds carried in the slave-side tuser
    typedef enum logic [2:0] {
        KIND_START    = 3'd0,
        KIND_RESPONSE = 3'd1,
        KIND_RETRY    = 3'd2,
        KIND_SEND     = 3'd3,
        KIND_TIMEOUT  = 3'd4,
        KIND_LINGER   = 3'd5,
        KIND_CLOSE    = 3'd6
    } t_kind;

    // Transaction states
    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_TRYING       = 3'd1,
        ST_CALLING      = 3'd2,
        ST_PROCEEDING   = 3'd3,
        ST_PROC_CALLING = 3'd4,
        ST_COMPLETED    = 3'd5,
        ST_TERMINATED   = 3'd6
    } t_state;

    // Send completion status
    localparam logic [1:0] WS_OK      = 2'd0;
    localparam logic [1:0] WS_PENDING = 2'd1;

    // Status code class boundaries
    localparam logic [9:0] CODE_CLASS1 = 10'd100;
    localparam logic [9:0] CODE_CLASS2 = 10'd200;
    localparam logic [9:0] CODE_CLASS3 = 10'd300;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic [2:0] kind;
        logic       is_invite;
        logic [9:0] status_code;
        logic [1:0] write_status;
    } t_event;

    // Packed LSB-last so deliver_response lands in bit 0 of tdata
    typedef struct packed {
        t_state state_now;
        logic   bad_event;
        logic   transport_error;
        logic   timed_out;
        logic   terminated;
        logic   stop_timers;
        logic   arm_linger;
        logic   arm_timeout;
        logic   arm_retry;
        logic   resend_request;
        logic   send_ack;
        logic   deliver_response;
    } t_action;

    localparam int ACTION_W = $bits(t_action);

endpackage

>>> hw/rtl/sip_client_transaction_fsm_core.sv
// Client transaction event decoder with one action word per event word.
// An accepted word passes through the input register and then the result register;
// master-side tvalid rises once the word reaches the result register.
// One word per cycle while the master side accepts; the next-state logic between the input
// register and the result register is purely combinational.
// Reset (synchronous, active low) empties both stages, returns the
// transaction to idle and selects datagram transport.
module sip_client_transaction_fsm_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_wr_data,   // stream_transport
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: is_invite[0], status_code[10:1], write_status[12:11], zero[15:13]
    input  logic [sipct_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: deliver_response[0], send_ack[1], resend_request[2], arm_retry[3],
    // arm_timeout[4], arm_linger[5], stop_timers[6], terminated[7], timed_out[8],
    // transport_error[9], bad_event[10], state_now[13:11], zero[15:14]
    output logic [sipct_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import sipct_pkg::*;

    logic    r_stream;
    logic    r_in_valid;
    t_event  r_in;
    logic    r_out_valid;
    t_action r_out;
    t_state  r_state;
    logic    r_invite;

    t_action n_action;
    t_state  n_state;
    logic    n_invite;
    logic    advance;

    // Move the held word into the result register when that is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - ACTION_W){1'b0}}, r_out};

    sipct_step u_step (
        .i_event  (r_in),
        .i_state  (r_state),
        .i_invite (r_invite),
        .i_stream (r_stream),
        .o_action (n_action),
        .o_state  (n_state),
        .o_invite (n_invite)
    );

    // Hold transport mode, input word, result word and transaction state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream    <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_IDLE;
            r_invite    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_stream <= i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_invite    <= n_invite;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.kind         <= s_axis_tuser;
            r_in.is_invite    <= s_axis_tdata[0];
            r_in.status_code  <= s_axis_tdata[10:1];
            r_in.write_status <= s_axis_tdata[12:11];
        end
        if (advance) begin
            r_out <= n_action;
        end
    end

    // Reported state matches the state register after each update
    a_state_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.state_now == r_state))
        else $error("reported state differs from transaction state");

    // Termination is only reported together with the terminated state
    a_term_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.terminated) |-> (r_out.state_now == ST_TERMINATED))
        else $error("termination reported outside terminated state");

    // Input stalls only when both stages are full and the output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a full pipeline");

endmodule

>>> hw/rtl/sipct_step.sv
module sipct_step (
    input  sipct_pkg::t_event  i_event,
    input  sipct_pkg::t_state  i_state,
    input  logic               i_invite,
    input  logic               i_stream,
    output sipct_pkg::t_action o_action,
    output sipct_pkg::t_state  o_state,
    output logic               o_invite
);
    import sipct_pkg::*;

    logic   live;
    logic   retry_ok;
    logic   cls1;
    logic   cls2;
    logic   cls3up;
    t_state rsp_next;

    // Classify the transaction and the status code
    always_comb begin
        live     = (i_state >= ST_TRYING) && (i_state <= ST_COMPLETED);
        retry_ok = i_invite ? (i_state == ST_CALLING)
                            : ((i_state == ST_TRYING) || (i_state == ST_PROCEEDING));
        cls1     = (i_event.status_code >= CODE_CLASS1)
                   && (i_event.status_code < CODE_CLASS2);
        cls2     = (i_event.status_code >= CODE_CLASS2)
                   && (i_event.status_code < CODE_CLASS3);
        cls3up   = (i_event.status_code >= CODE_CLASS3);
    end

    // Next state for a response, before the reliable-transport shortcut
    always_comb begin
        rsp_next = i_state;
        unique case (i_state)
            ST_TRYING: begin
                rsp_next = cls1 ? ST_PROCEEDING : ST_COMPLETED;
            end
            ST_CALLING: begin
                if (cls1)      rsp_next = ST_PROC_CALLING;
                else if (cls2) rsp_next = ST_TERMINATED;
                else           rsp_next = ST_COMPLETED;
            end
            ST_PROCEEDING: begin
                if (!cls1) rsp_next = ST_COMPLETED;
            end
            ST_PROC_CALLING: begin
                if (cls2)       rsp_next = ST_TERMINATED;
                else if (!cls1) rsp_next = ST_COMPLETED;
            end
            default: begin
                rsp_next = i_state;
            end
        endcase
    end

    // Decode the event into an action word and the new state
    always_comb begin
        o_action = '0;
        o_state  = i_state;
        o_invite = i_invite;
        unique case (t_kind'(i_event.kind))
            KIND_START: begin
                if (live) begin
                    o_action.bad_event = 1'b1;
                end else begin
                    o_invite             = i_event.is_invite;
                    o_state              = i_event.is_invite ? ST_CALLING : ST_TRYING;
                    o_action.arm_retry   = !i_stream;
                    o_action.arm_timeout = 1'b1;
                end
            end
            KIND_RESPONSE: begin
                if (!live) begin
                    o_action.bad_event = 1'b1;
                end else begin
                    o_action.deliver_response = (i_state != ST_COMPLETED);
                    o_action.send_ack         = i_invite && cls3up;
                    o_action.stop_timers      = (i_state == ST_CALLING)
                                                && (rsp_next == ST_PROC_CALLING);
                    o_state = rsp_next;
                    if (rsp_next == ST_COMPLETED) begin
                        if (i_stream) o_state = ST_TERMINATED;
                        else          o_action.arm_linger = (i_state != ST_COMPLETED);
                    end
                    o_action.terminated = (i_stream && (rsp_next == ST_COMPLETED))
                                          || (rsp_next == ST_TERMINATED);
                end
            end
            KIND_RETRY: begin
                if (!i_stream && retry_ok) o_action.resend_request = 1'b1;
                else                       o_action.bad_event      = 1'b1;
            end
            KIND_SEND: begin
                if (!live) begin
                    o_action.bad_event = 1'b1;
                end else if (i_event.write_status == WS_OK) begin
                    o_action.arm_retry = !i_stream && retry_ok;
                end else if (i_event.write_status != WS_PENDING) begin
                    o_action.transport_error = 1'b1;
                end
            end
            KIND_TIMEOUT: begin
                if (retry_ok) begin
                    o_state             = ST_TERMINATED;
                    o_action.timed_out  = 1'b1;
                    o_action.terminated = 1'b1;
                end else begin
                    o_action.bad_event = 1'b1;
                end
            end
            KIND_LINGER: begin
                if (!i_stream && (i_state == ST_COMPLETED)) begin
                    o_state             = ST_TERMINATED;
                    o_action.terminated = 1'b1;
                end else begin
                    o_action.bad_event = 1'b1;
                end
            end
            KIND_CLOSE: begin
                o_action.stop_timers = 1'b1;
            end
            default: begin
                o_action.bad_event = 1'b1;
            end
        endcase
        o_action.state_now = o_state;
    end

endmodule
